[rtl/core/pcm_pkg.sv]
package pcm_pkg;

  // Register map of the configuration port
  typedef enum logic [2:0] {
    CfgInvXCoefs  = 3'd0,
    CfgInvXOffset = 3'd1,
    CfgInvYCoefs  = 3'd2,
    CfgInvYOffset = 3'd3,
    CfgInvWCoefs  = 3'd4,
    CfgInvWOffset = 3'd5,
    CfgSourceSize = 3'd6
  } cfg_idx_e;

  localparam int unsigned CoordW  = 12;  // dest_x / dest_y
  localparam int unsigned SrcW    = 20;  // src_x / src_y, Q12.8
  localparam int unsigned CoefW   = 32;  // one matrix entry
  localparam int unsigned ProdW   = CoefW + CoordW + 1;
  localparam int unsigned SumW    = 48;  // w, nx, ny after the dot product
  localparam int unsigned FracW   = 22;  // quotient bits below the Q.16/Q.30 point
  localparam int unsigned WShift  = 14;  // m22 from Q.16 to Q.30
  localparam int unsigned OutFrac = 8;

  localparam logic [63:0] XCoefsRst  = 64'd65536;
  localparam logic [31:0] XOffsetRst = 32'd0;
  localparam logic [63:0] YCoefsRst  = 64'd281474976710656;
  localparam logic [31:0] YOffsetRst = 32'd0;
  localparam logic [63:0] WCoefsRst  = 64'd0;
  localparam logic [31:0] WOffsetRst = 32'd65536;
  localparam logic [28:0] SizeRst    = 29'd268439552;

endpackage

[rtl/core/perspective_coordinate_mapper.sv]
// Inverse perspective mapper: takes one output pixel coordinate per word on the slave
// stream and returns the source coordinate under the configured inverse homography as
// unsigned Q12.8, with an inside flag (point within the source image and w nonzero;
// outside points read as zero). A new word is accepted every clock while the output is
// not stalled. The restoring divider retires one quotient bit per pipeline stage for x
// and y side by side. The whole pipeline advances together and holds while a finished
// word waits on the master side. Write configuration only while the pipeline is empty;
// the port never stalls.
module perspective_coordinate_mapper
  import pcm_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // input coordinates
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // dest_x [11:0], dest_y [23:12]
  // mapped coordinates
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // dest_x_out, dest_y_out, src_x, src_y (low first)
  output logic [0:0]  m_axis_tuser    // inside_res
);

  localparam int unsigned QW   = $clog2(MAX_DIM) + OutFrac;  // quotient bits kept
  localparam int unsigned DimW = $clog2(MAX_DIM) + 1;
  localparam int unsigned RW   = SumW + ((FracW > QW) ? FracW : QW);

  typedef struct packed {
    logic                        vld;
    logic [CoordW-1:0]           dx;
    logic [CoordW-1:0]           dy;
    logic signed [ProdW-1:0]     px0, px1, py0, py1, pw0, pw1;
  } mul_t;

  typedef struct packed {
    logic                        vld;
    logic [CoordW-1:0]           dx;
    logic [CoordW-1:0]           dy;
    logic signed [SumW-1:0]      nx, ny, w;
  } sum_t;

  typedef struct packed {
    logic                        vld;
    logic [CoordW-1:0]           dx;
    logic [CoordW-1:0]           dy;
    logic [SumW-1:0]             ax, ay, b;
    logic                        okx, oky, wnz;
  } mag_t;

  typedef struct packed {
    logic                        vld;
    logic [CoordW-1:0]           dx;
    logic [CoordW-1:0]           dy;
    logic [RW-1:0]               rx, ry;
    logic [SumW-1:0]             b;
    logic [QW-1:0]               qx, qy;
    logic                        okx, oky, wnz;
  } div_t;

  // configuration registers
  logic [63:0] x_coefs_q, y_coefs_q, w_coefs_q;
  logic [31:0] x_off_q, y_off_q, w_off_q;
  logic [28:0] size_q;

  logic en;
  mul_t mul_q;
  sum_t sum_q;
  mag_t mag_q;
  div_t dv_q [QW+1];
  logic        out_vld_q;
  logic [63:0] out_data_q;
  logic        out_in_q;

  logic [DimW-1:0] wlim, hlim;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_coefs_q <= XCoefsRst;
      x_off_q   <= XOffsetRst;
      y_coefs_q <= YCoefsRst;
      y_off_q   <= YOffsetRst;
      w_coefs_q <= WCoefsRst;
      w_off_q   <= WOffsetRst;
      size_q    <= SizeRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgInvXCoefs:  x_coefs_q <= cfg_data_i;
        CfgInvXOffset: x_off_q   <= cfg_data_i[31:0];
        CfgInvYCoefs:  y_coefs_q <= cfg_data_i;
        CfgInvYOffset: y_off_q   <= cfg_data_i[31:0];
        CfgInvWCoefs:  w_coefs_q <= cfg_data_i;
        CfgInvWOffset: w_off_q   <= cfg_data_i[31:0];
        CfgSourceSize: size_q    <= cfg_data_i[28:0];
        default: ;
      endcase
    end
  end

  // Advance everything together; hold only while the output word is refused.
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: six 13x32 products
  mul_t mul_d;
  logic signed [CoordW:0] sdx, sdy;
  assign sdx = signed'({1'b0, s_axis_tdata[11:0]});
  assign sdy = signed'({1'b0, s_axis_tdata[23:12]});
  always_comb begin
    mul_d     = '0;
    mul_d.vld = s_axis_tvalid;
    mul_d.dx  = s_axis_tdata[11:0];
    mul_d.dy  = s_axis_tdata[23:12];
    mul_d.px0 = sdx * signed'(x_coefs_q[31:0]);
    mul_d.px1 = sdy * signed'(x_coefs_q[63:32]);
    mul_d.py0 = sdx * signed'(y_coefs_q[31:0]);
    mul_d.py1 = sdy * signed'(y_coefs_q[63:32]);
    mul_d.pw0 = sdx * signed'(w_coefs_q[31:0]);
    mul_d.pw1 = sdy * signed'(w_coefs_q[63:32]);
  end

  // Stage 2: sums, w brought to Q.30
  sum_t sum_d;
  always_comb begin
    sum_d     = '0;
    sum_d.vld = mul_q.vld;
    sum_d.dx  = mul_q.dx;
    sum_d.dy  = mul_q.dy;
    sum_d.nx  = SumW'(mul_q.px0) + SumW'(mul_q.px1) + SumW'(signed'(x_off_q));
    sum_d.ny  = SumW'(mul_q.py0) + SumW'(mul_q.py1) + SumW'(signed'(y_off_q));
    sum_d.w   = SumW'(mul_q.pw0) + SumW'(mul_q.pw1) + (SumW'(signed'(w_off_q)) <<< WShift);
  end

  // Stage 3: magnitudes; drop any strictly negative quotient
  mag_t mag_d;
  always_comb begin
    mag_d     = '0;
    mag_d.vld = sum_q.vld;
    mag_d.dx  = sum_q.dx;
    mag_d.dy  = sum_q.dy;
    mag_d.ax  = sum_q.nx[SumW-1] ? SumW'(-sum_q.nx) : SumW'(sum_q.nx);
    mag_d.ay  = sum_q.ny[SumW-1] ? SumW'(-sum_q.ny) : SumW'(sum_q.ny);
    mag_d.b   = sum_q.w[SumW-1]  ? SumW'(-sum_q.w)  : SumW'(sum_q.w);
    mag_d.wnz = (sum_q.w != '0);
    mag_d.okx = (sum_q.nx == '0) || (sum_q.nx[SumW-1] == sum_q.w[SumW-1]);
    mag_d.oky = (sum_q.ny == '0) || (sum_q.ny[SumW-1] == sum_q.w[SumW-1]);
  end

  // Stage 4: scale dividends, reject quotients with bits above the kept range
  div_t dv_d0;
  logic [RW-1:0] bmax;
  always_comb begin
    bmax      = RW'(mag_q.b) << QW;
    dv_d0     = '0;
    dv_d0.vld = mag_q.vld;
    dv_d0.dx  = mag_q.dx;
    dv_d0.dy  = mag_q.dy;
    dv_d0.b   = mag_q.b;
    dv_d0.wnz = mag_q.wnz;
    dv_d0.rx  = RW'(mag_q.ax) << FracW;
    dv_d0.ry  = RW'(mag_q.ay) << FracW;
    dv_d0.okx = mag_q.okx && (dv_d0.rx < bmax);
    dv_d0.oky = mag_q.oky && (dv_d0.ry < bmax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q    <= '0;
      sum_q    <= '0;
      mag_q    <= '0;
      dv_q[0]  <= '0;
    end else if (en) begin
      mul_q    <= mul_d;
      sum_q    <= sum_d;
      mag_q    <= mag_d;
      dv_q[0]  <= dv_d0;
    end
  end

  // Restoring division: one quotient bit per stage, most significant first
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int unsigned K = QW - 1 - j;
    logic [RW-1:0] dvs;
    logic          tx, ty;
    div_t          dv_d;
    assign dvs = RW'(dv_q[j].b) << K;
    assign tx  = dv_q[j].rx >= dvs;
    assign ty  = dv_q[j].ry >= dvs;
    always_comb begin
      dv_d    = dv_q[j];
      dv_d.rx = tx ? dv_q[j].rx - dvs : dv_q[j].rx;
      dv_d.ry = ty ? dv_q[j].ry - dvs : dv_q[j].ry;
      dv_d.qx = {dv_q[j].qx[QW-2:0], tx};
      dv_d.qy = {dv_q[j].qy[QW-2:0], ty};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= '0;
      end else if (en) begin
        dv_q[j+1] <= dv_d;
      end
    end
  end

  // Final stage: bound against the source size, clear outside points
  assign wlim = (32'(size_q[15:0]) > 32'(MAX_DIM)) ? DimW'(MAX_DIM) : DimW'(size_q[15:0]);
  assign hlim = (32'(size_q[28:16]) > 32'(MAX_DIM)) ? DimW'(MAX_DIM) : DimW'(size_q[28:16]);

  logic            fin_x, fin_y, in_src;
  logic [SrcW-1:0] sx, sy;
  assign fin_x  = dv_q[QW].okx && ({1'b0, dv_q[QW].qx} < (QW+1)'({wlim, 8'b0}));
  assign fin_y  = dv_q[QW].oky && ({1'b0, dv_q[QW].qy} < (QW+1)'({hlim, 8'b0}));
  assign in_src = dv_q[QW].wnz && fin_x && fin_y;
  assign sx     = in_src ? SrcW'(dv_q[QW].qx) : '0;
  assign sy     = in_src ? SrcW'(dv_q[QW].qy) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
      out_in_q   <= 1'b0;
    end else if (en) begin
      out_vld_q  <= dv_q[QW].vld;
      out_data_q <= {sy, sx, dv_q[QW].dy, dv_q[QW].dx};
      out_in_q   <= in_src;
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_in_q;

`ifndef ASSERT_OFF
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[63:24] == '0)
    else $error("outside point carries a nonzero source coordinate");

  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready disagrees with output stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> mul_q.vld)
    else $error("accepted word missing from first stage");

  a_zero_w_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && dv_q[QW].vld && !dv_q[QW].wnz |=> !m_axis_tuser[0])
    else $error("zero w reported inside");
`endif

endmodule
